[sv/tur_pkg.sv]
`default_nettype none

package tur_pkg;

    localparam int TS_W      = 32;
    localparam int TICK_W    = 48;
    localparam int PCT_W     = 7;
    localparam int SUM_W     = 24;
    localparam int CNT_W     = 16;
    localparam int SLOT_W    = 16;
    localparam int TIER_OUT_W = 3;
    localparam int INTV_W    = 16;
    localparam int TSLOT_W   = 8;
    localparam int NUM_INTV  = 4;
    localparam int NUM_W     = 55;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int DIV_LO_W       = 32;
    localparam int DIV_CNT_W      = 6;
    localparam int DIV_SHORT_STEPS = 7;
    localparam int DIV_LONG_STEPS  = 32;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [INTV_W-1:0]  RAW_INTERVAL_RST = 16'd10;
    localparam logic [INTV_W-1:0]  RAW_SLOTS_RST    = 16'd60480;
    localparam logic [INTV_W-1:0]  TIER1_RST        = 16'd30;
    localparam logic [INTV_W-1:0]  TIER2_RST        = 16'd180;
    localparam logic [INTV_W-1:0]  TIER3_RST        = 16'd360;
    localparam logic [INTV_W-1:0]  TIER4_RST        = 16'd720;
    localparam logic [TSLOT_W-1:0] TIER_SLOTS_RST   = 8'd120;

    typedef enum logic [2:0] {
        REG_RAW_INTERVAL   = 3'd0,
        REG_RAW_SLOTS      = 3'd1,
        REG_TIER1_INTERVAL = 3'd2,
        REG_TIER2_INTERVAL = 3'd3,
        REG_TIER3_INTERVAL = 3'd4,
        REG_TIER4_INTERVAL = 3'd5,
        REG_TIER_SLOTS     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [INTV_W-1:0]                raw_interval;
        logic [INTV_W-1:0]                raw_slots;
        logic [NUM_INTV-1:0][INTV_W-1:0]  tier_interval;
        logic [TSLOT_W-1:0]               tier_slots;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic                 short_mode;
        logic [TICK_W-1:0]    dividend_hi;
        logic [DIV_LO_W-1:0]  dividend_lo;
        logic [TICK_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_LO_W-1:0]  quotient;
        logic [TICK_W-1:0]    remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/tiered_usage_rollup_unit.sv]
// Rollup of cpu and memory usage samples into a raw ring and up to four rollup
// tiers. Each accepted sample is compared with the previous cpu counters; when
// the cpu reading is valid, the total advanced, a previous sample exists and
// memory is valid, the block returns one raw record (tier 0) followed by one
// record per rollup tier, the final one marked with last. Otherwise it returns
// nothing and only updates the stored counters. All divisions (busy percent,
// buckets, ring slots, rounded means) run on one shared radix-2 divider, one
// quotient bit per cycle. A full sample waits in its emit states while the
// output is stalled. Input is stalled while a sample is in work; the last
// record may still wait in the output register while the next sample is taken.
// Configuration registers sit on the APB port at byte address 4 * index.
`default_nettype none

module tiered_usage_rollup_unit
    import tur_pkg::*;
#(
    parameter int ROLLUP_TIERS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TS_W-1:0]       timestamp,
    input  logic [TICK_W-1:0]     cpu_total_ticks,
    input  logic [TICK_W-1:0]     cpu_idle_ticks,
    input  logic                  cpu_valid,
    input  logic [PCT_W-1:0]      mem_percent,
    input  logic                  mem_valid,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TIER_OUT_W-1:0] tier,
    output logic [SLOT_W-1:0]     slot,
    output logic [TS_W-1:0]       bucket,
    output logic [PCT_W-1:0]      cpu_average,
    output logic [PCT_W-1:0]      cpu_peak,
    output logic [PCT_W-1:0]      mem_average,
    output logic [PCT_W-1:0]      mem_peak,
    output logic                  last,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int NUM_TIERS = (ROLLUP_TIERS < NUM_INTV) ? ROLLUP_TIERS : NUM_INTV;
    localparam int TIER_W    = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
    localparam logic [TIER_W-1:0] LAST_TIER = TIER_W'(NUM_TIERS - 1);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_CHECK    = 14'b00000000000010,
        S_CLAMP    = 14'b00000000000100,
        S_NUM      = 14'b00000000001000,
        S_CPU      = 14'b00000000010000,
        S_RAW_BKT  = 14'b00000000100000,
        S_RAW_SLOT = 14'b00000001000000,
        S_RAW_EMIT = 14'b00000010000000,
        S_TBKT     = 14'b00000100000000,
        S_TUPD     = 14'b00001000000000,
        S_TSLOT    = 14'b00010000000000,
        S_TCAVG    = 14'b00100000000000,
        S_TMAVG    = 14'b01000000000000,
        S_TEMIT    = 14'b10000000000000
    } state_t;

    function automatic logic [INTV_W-1:0] nz16(input logic [INTV_W-1:0] v);
        nz16 = (v == '0) ? INTV_W'(1) : v;
    endfunction

    function automatic logic [TSLOT_W-1:0] nz8(input logic [TSLOT_W-1:0] v);
        nz8 = (v == '0) ? TSLOT_W'(1) : v;
    endfunction

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg;
    state_t state_next;

    logic [TS_W-1:0]   ts_reg;
    logic [TICK_W-1:0] smp_total_reg;
    logic [TICK_W-1:0] smp_idle_reg;
    logic              cpu_ok_reg;
    logic [PCT_W-1:0]  mem_reg;
    logic              mem_ok_reg;

    logic [TICK_W-1:0] old_total_reg;
    logic [TICK_W-1:0] old_idle_reg;
    logic              old_ok_reg;

    logic [TICK_W-1:0] total_reg;
    logic [TICK_W-1:0] idle_d_reg;
    logic              idle_neg_reg;
    logic [TICK_W-1:0] busy_ticks_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [PCT_W-1:0]  cpu_reg;
    logic [TS_W-1:0]   bkt_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PCT_W-1:0]  cavg_reg;
    logic [PCT_W-1:0]  mavg_reg;
    logic [TIER_W-1:0] tier_idx_reg;
    logic              div_pend_reg;

    logic [TS_W-1:0]   agg_bucket_reg  [NUM_TIERS];
    logic [SUM_W-1:0]  agg_cpu_sum_reg [NUM_TIERS];
    logic [SUM_W-1:0]  agg_mem_sum_reg [NUM_TIERS];
    logic [PCT_W-1:0]  agg_cpu_max_reg [NUM_TIERS];
    logic [PCT_W-1:0]  agg_mem_max_reg [NUM_TIERS];
    logic [CNT_W-1:0]  agg_count_reg   [NUM_TIERS];

    logic                  out_valid_reg;
    logic [TIER_OUT_W-1:0] out_tier_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [TS_W-1:0]       out_bucket_reg;
    logic [PCT_W-1:0]      out_cavg_reg;
    logic [PCT_W-1:0]      out_cpeak_reg;
    logic [PCT_W-1:0]      out_mavg_reg;
    logic [PCT_W-1:0]      out_mpeak_reg;
    logic                  out_last_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;
    logic              div_state;
    logic [TICK_W:0]   tot_diff;
    logic [TICK_W:0]   idl_diff;
    logic [TICK_W:0]   busy_diff;
    logic              advance;
    logic [NUM_W-1:0]  busy_ext;
    logic [NUM_W-1:0]  num_next;
    logic              fresh;
    logic [SUM_W-1:0]  base_cpu_sum;
    logic [SUM_W-1:0]  base_mem_sum;
    logic [PCT_W-1:0]  base_cpu_max;
    logic [PCT_W-1:0]  base_mem_max;
    logic [CNT_W-1:0]  base_count;
    logic              room;
    logic [SUM_W-1:0]  cpu_sum_next;
    logic [SUM_W-1:0]  mem_sum_next;
    logic [CNT_W-1:0]  count_next;
    logic [PCT_W-1:0]  cpu_max_next;
    logic [PCT_W-1:0]  mem_max_next;
    logic              last_tier;

    tur_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tur_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign tot_diff = {1'b0, smp_total_reg} - {1'b0, old_total_reg};
    assign idl_diff = {1'b0, smp_idle_reg} - {1'b0, old_idle_reg};
    assign advance  = old_ok_reg && cpu_ok_reg && !tot_diff[TICK_W]
                      && (tot_diff[TICK_W-1:0] != '0);
    assign busy_diff = {1'b0, total_reg} - {1'b0, idle_d_reg};

    // busy * 100 + total / 2
    assign busy_ext = NUM_W'(busy_ticks_reg);
    assign num_next = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2)
                      + NUM_W'(total_reg[TICK_W-1:1]);

    assign last_tier = (tier_idx_reg == LAST_TIER);

    always_comb
    begin
        fresh        = (agg_bucket_reg[tier_idx_reg] != bkt_reg);
        base_cpu_sum = fresh ? '0 : agg_cpu_sum_reg[tier_idx_reg];
        base_mem_sum = fresh ? '0 : agg_mem_sum_reg[tier_idx_reg];
        base_cpu_max = fresh ? '0 : agg_cpu_max_reg[tier_idx_reg];
        base_mem_max = fresh ? '0 : agg_mem_max_reg[tier_idx_reg];
        base_count   = fresh ? '0 : agg_count_reg[tier_idx_reg];
        room         = (base_count != CNT_MAX);
        cpu_sum_next = room ? base_cpu_sum + SUM_W'(cpu_reg) : base_cpu_sum;
        mem_sum_next = room ? base_mem_sum + SUM_W'(mem_reg) : base_mem_sum;
        count_next   = room ? base_count + 1'b1 : base_count;
        cpu_max_next = (cpu_reg > base_cpu_max) ? cpu_reg : base_cpu_max;
        mem_max_next = (mem_reg > base_mem_max) ? mem_reg : base_mem_max;
    end

    always_comb
    begin
        state_next = state_reg;
        div_state  = 1'b0;
        load_out   = 1'b0;
        div_req    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (advance && mem_ok_reg) ? S_CLAMP : S_IDLE;
            end
            S_CLAMP:
            begin
                state_next = S_NUM;
            end
            S_NUM:
            begin
                state_next = S_CPU;
            end
            S_CPU:
            begin
                div_state              = 1'b1;
                div_req.short_mode     = 1'b1;
                div_req.dividend_hi    = num_reg[NUM_W-1:DIV_SHORT_STEPS];
                div_req.dividend_lo    = {num_reg[DIV_SHORT_STEPS-1:0],
                                          (DIV_LO_W - DIV_SHORT_STEPS)'(0)};
                div_req.divisor        = total_reg;
                if (div_rsp.done)
                    state_next = S_RAW_BKT;
            end
            S_RAW_BKT:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = ts_reg;
                div_req.divisor     = TICK_W'(nz16(cfg.raw_interval));
                if (div_rsp.done)
                    state_next = S_RAW_SLOT;
            end
            S_RAW_SLOT:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = bkt_reg;
                div_req.divisor     = TICK_W'(nz16(cfg.raw_slots));
                if (div_rsp.done)
                    state_next = S_RAW_EMIT;
            end
            S_RAW_EMIT:
            begin
                load_out = out_free;
                if (out_free)
                    state_next = S_TBKT;
            end
            S_TBKT:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = ts_reg;
                div_req.divisor     = TICK_W'(nz16(cfg.tier_interval[tier_idx_reg]));
                if (div_rsp.done)
                    state_next = S_TUPD;
            end
            S_TUPD:
            begin
                state_next = S_TSLOT;
            end
            S_TSLOT:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = bkt_reg;
                div_req.divisor     = TICK_W'(nz8(cfg.tier_slots));
                if (div_rsp.done)
                    state_next = S_TCAVG;
            end
            S_TCAVG:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = DIV_LO_W'(agg_cpu_sum_reg[tier_idx_reg]
                                      + SUM_W'(agg_count_reg[tier_idx_reg] >> 1));
                div_req.divisor     = TICK_W'(agg_count_reg[tier_idx_reg]);
                if (div_rsp.done)
                    state_next = S_TMAVG;
            end
            S_TMAVG:
            begin
                div_state           = 1'b1;
                div_req.dividend_lo = DIV_LO_W'(agg_mem_sum_reg[tier_idx_reg]
                                      + SUM_W'(agg_count_reg[tier_idx_reg] >> 1));
                div_req.divisor     = TICK_W'(agg_count_reg[tier_idx_reg]);
                if (div_rsp.done)
                    state_next = S_TEMIT;
            end
            S_TEMIT:
            begin
                load_out = out_free;
                if (out_free)
                    state_next = last_tier ? S_IDLE : S_TBKT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        div_req.start = div_state && !div_pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_pend_reg  <= 1'b0;
            old_ok_reg    <= 1'b0;
            old_total_reg <= '0;
            old_idle_reg  <= '0;
            tier_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIERS; i++)
            begin
                agg_bucket_reg[i]  <= '0;
                agg_cpu_sum_reg[i] <= '0;
                agg_mem_sum_reg[i] <= '0;
                agg_cpu_max_reg[i] <= '0;
                agg_mem_max_reg[i] <= '0;
                agg_count_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (div_req.start)
                div_pend_reg <= 1'b1;
            else if (div_rsp.done)
                div_pend_reg <= 1'b0;

            if (state_reg == S_CHECK)
            begin
                old_total_reg <= smp_total_reg;
                old_idle_reg  <= smp_idle_reg;
                old_ok_reg    <= cpu_ok_reg;
            end

            if (state_reg == S_RAW_EMIT)
                tier_idx_reg <= '0;
            else if (state_reg == S_TEMIT && out_free && !last_tier)
                tier_idx_reg <= tier_idx_reg + 1'b1;

            if (state_reg == S_TUPD)
            begin
                agg_bucket_reg[tier_idx_reg]  <= bkt_reg;
                agg_cpu_sum_reg[tier_idx_reg] <= cpu_sum_next;
                agg_mem_sum_reg[tier_idx_reg] <= mem_sum_next;
                agg_cpu_max_reg[tier_idx_reg] <= cpu_max_next;
                agg_mem_max_reg[tier_idx_reg] <= mem_max_next;
                agg_count_reg[tier_idx_reg]   <= count_next;
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg        <= timestamp;
            smp_total_reg <= cpu_valid ? cpu_total_ticks : '0;
            smp_idle_reg  <= cpu_valid ? cpu_idle_ticks : '0;
            cpu_ok_reg    <= cpu_valid;
            mem_reg       <= (mem_percent > PCT_MAX) ? PCT_MAX : mem_percent;
            mem_ok_reg    <= mem_valid;
        end

        if (state_reg == S_CHECK)
        begin
            total_reg    <= tot_diff[TICK_W-1:0];
            idle_d_reg   <= idl_diff[TICK_W-1:0];
            idle_neg_reg <= idl_diff[TICK_W];
        end

        // idle that went backwards or beyond the total leaves no busy ticks
        if (state_reg == S_CLAMP)
            busy_ticks_reg <= (idle_neg_reg || busy_diff[TICK_W]) ? '0
                                                                  : busy_diff[TICK_W-1:0];

        if (state_reg == S_NUM)
            num_reg <= num_next;

        if (div_rsp.done)
        begin
            unique case (state_reg) inside
                S_CPU:                 cpu_reg  <= div_rsp.quotient[PCT_W-1:0];
                S_RAW_BKT, S_TBKT:     bkt_reg  <= div_rsp.quotient;
                S_RAW_SLOT, S_TSLOT:   slot_reg <= div_rsp.remainder[SLOT_W-1:0];
                S_TCAVG:               cavg_reg <= div_rsp.quotient[PCT_W-1:0];
                S_TMAVG:               mavg_reg <= div_rsp.quotient[PCT_W-1:0];
                default: ;
            endcase
        end

        if (load_out)
        begin
            out_slot_reg   <= slot_reg;
            out_bucket_reg <= bkt_reg;
            if (state_reg == S_RAW_EMIT)
            begin
                out_tier_reg  <= '0;
                out_cavg_reg  <= cpu_reg;
                out_cpeak_reg <= cpu_reg;
                out_mavg_reg  <= mem_reg;
                out_mpeak_reg <= mem_reg;
                out_last_reg  <= 1'b0;
            end
            else
            begin
                out_tier_reg  <= TIER_OUT_W'(tier_idx_reg) + 1'b1;
                out_cavg_reg  <= cavg_reg;
                out_cpeak_reg <= agg_cpu_max_reg[tier_idx_reg];
                out_mavg_reg  <= mavg_reg;
                out_mpeak_reg <= agg_mem_max_reg[tier_idx_reg];
                out_last_reg  <= last_tier;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign tier        = out_tier_reg;
    assign slot        = out_slot_reg;
    assign bucket      = out_bucket_reg;
    assign cpu_average = out_cavg_reg;
    assign cpu_peak    = out_cpeak_reg;
    assign mem_average = out_mavg_reg;
    assign mem_peak    = out_mpeak_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

[sv/tur_div.sv]
`default_nettype none

module tur_div
    import tur_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [TICK_W-1:0]    rem_reg;
    logic [TICK_W-1:0]    rem_next;
    logic [DIV_LO_W-1:0]  dq_reg;
    logic [DIV_LO_W-1:0]  dq_next;
    logic [TICK_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TICK_W+1:0]    diff;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign diff = {1'b0, rem_reg, dq_reg[DIV_LO_W-1]} - {2'b00, dsr_reg};
    assign fits = !diff[TICK_W+1];

    always_comb
    begin
        rem_next = fits ? diff[TICK_W-1:0] : {rem_reg[TICK_W-2:0], dq_reg[DIV_LO_W-1]};
        dq_next  = {dq_reg[DIV_LO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.short_mode ? DIV_CNT_W'(DIV_SHORT_STEPS)
                                           : DIV_CNT_W'(DIV_LONG_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend_hi;
            dq_reg  <= req.dividend_lo;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[sv/tur_regs.sv]
`default_nettype none

module tur_regs
    import tur_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_interval     <= RAW_INTERVAL_RST;
            cfg_reg.raw_slots        <= RAW_SLOTS_RST;
            cfg_reg.tier_interval[0] <= TIER1_RST;
            cfg_reg.tier_interval[1] <= TIER2_RST;
            cfg_reg.tier_interval[2] <= TIER3_RST;
            cfg_reg.tier_interval[3] <= TIER4_RST;
            cfg_reg.tier_slots       <= TIER_SLOTS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RAW_INTERVAL:   cfg_reg.raw_interval     <= pwdata[INTV_W-1:0];
                REG_RAW_SLOTS:      cfg_reg.raw_slots        <= pwdata[INTV_W-1:0];
                REG_TIER1_INTERVAL: cfg_reg.tier_interval[0] <= pwdata[INTV_W-1:0];
                REG_TIER2_INTERVAL: cfg_reg.tier_interval[1] <= pwdata[INTV_W-1:0];
                REG_TIER3_INTERVAL: cfg_reg.tier_interval[2] <= pwdata[INTV_W-1:0];
                REG_TIER4_INTERVAL: cfg_reg.tier_interval[3] <= pwdata[INTV_W-1:0];
                REG_TIER_SLOTS:     cfg_reg.tier_slots       <= pwdata[TSLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_RAW_INTERVAL:   prdata = DATA_W'(cfg_reg.raw_interval);
            REG_RAW_SLOTS:      prdata = DATA_W'(cfg_reg.raw_slots);
            REG_TIER1_INTERVAL: prdata = DATA_W'(cfg_reg.tier_interval[0]);
            REG_TIER2_INTERVAL: prdata = DATA_W'(cfg_reg.tier_interval[1]);
            REG_TIER3_INTERVAL: prdata = DATA_W'(cfg_reg.tier_interval[2]);
            REG_TIER4_INTERVAL: prdata = DATA_W'(cfg_reg.tier_interval[3]);
            REG_TIER_SLOTS:     prdata = DATA_W'(cfg_reg.tier_slots);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/tur_checker.sv]
`default_nettype none

module tur_checker
    import tur_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [TIER_OUT_W-1:0] tier,
    input logic [SLOT_W-1:0]     slot,
    input logic [TS_W-1:0]       bucket,
    input logic [PCT_W-1:0]      cpu_average,
    input logic [PCT_W-1:0]      cpu_peak,
    input logic [PCT_W-1:0]      mem_average,
    input logic [PCT_W-1:0]      mem_peak,
    input logic                  last
);

    // a taken sample stalls the input in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tier) && $stable(bucket)
                                   && $stable(slot) && $stable(last))
    else $error("stalled record changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cpu_average <= cpu_peak && mem_average <= mem_peak
                      && cpu_peak <= PCT_MAX && mem_peak <= PCT_MAX)
    else $error("mean above peak or peak above 100");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tier <= TIER_OUT_W'(NUM_INTV) && !(tier == '0 && last)
                      && TS_W'(slot) <= bucket)
    else $error("bad tier, last flag or slot");

endmodule

bind tiered_usage_rollup_unit tur_checker u_checker (.*);

`default_nettype wire

[tb/tiered_usage_rollup_unit_tb.sv]
`timescale 1ns / 1ps

module tiered_usage_rollup_unit_tb
    import tur_pkg::*;
();

    localparam int TIERS        = 4;
    localparam int ACTIVE_TIERS = (TIERS < 4) ? TIERS : 4;
    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [TS_W-1:0]   ts;
        logic [TICK_W-1:0] total;
        logic [TICK_W-1:0] idle;
        logic              cpu_ok;
        logic [PCT_W-1:0]  mem;
        logic              mem_ok;
    } sample_t;

    typedef struct {
        logic [TIER_OUT_W-1:0] tier;
        logic [SLOT_W-1:0]     slot;
        logic [TS_W-1:0]       bucket;
        logic [PCT_W-1:0]      cpu_avg;
        logic [PCT_W-1:0]      cpu_pk;
        logic [PCT_W-1:0]      mem_avg;
        logic [PCT_W-1:0]      mem_pk;
        logic                  last;
    } rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TS_W-1:0]       timestamp = '0;
    logic [TICK_W-1:0]     cpu_total_ticks = '0;
    logic [TICK_W-1:0]     cpu_idle_ticks = '0;
    logic                  cpu_valid = 1'b0;
    logic [PCT_W-1:0]      mem_percent = '0;
    logic                  mem_valid = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [TIER_OUT_W-1:0] tier;
    logic [SLOT_W-1:0]     slot;
    logic [TS_W-1:0]       bucket;
    logic [PCT_W-1:0]      cpu_average;
    logic [PCT_W-1:0]      cpu_peak;
    logic [PCT_W-1:0]      mem_average;
    logic [PCT_W-1:0]      mem_peak;
    logic                  last;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    tiered_usage_rollup_unit #(
        .ROLLUP_TIERS (TIERS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .timestamp       (timestamp),
        .cpu_total_ticks (cpu_total_ticks),
        .cpu_idle_ticks  (cpu_idle_ticks),
        .cpu_valid       (cpu_valid),
        .mem_percent     (mem_percent),
        .mem_valid       (mem_valid),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tier            (tier),
        .slot            (slot),
        .bucket          (bucket),
        .cpu_average     (cpu_average),
        .cpu_peak        (cpu_peak),
        .mem_average     (mem_average),
        .mem_peak        (mem_peak),
        .last            (last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // register copy
    logic [INTV_W-1:0]  raw_interval_cfg = RAW_INTERVAL_RST;
    logic [INTV_W-1:0]  raw_slots_cfg = RAW_SLOTS_RST;
    logic [INTV_W-1:0]  tier_interval_cfg [4];
    logic [TSLOT_W-1:0] tier_slots_cfg = TIER_SLOTS_RST;

    // rollup state
    logic [TICK_W-1:0] old_total = '0;
    logic [TICK_W-1:0] old_idle = '0;
    logic              old_ok = 1'b0;
    logic [31:0]       agg_bucket [4];
    logic [31:0]       agg_cpu_sum [4];
    logic [31:0]       agg_mem_sum [4];
    logic [31:0]       agg_cpu_max [4];
    logic [31:0]       agg_mem_max [4];
    logic [31:0]       agg_count [4];

    sample_t sample_q [$];
    rec_t    record_q [$];
    sample_t driven_sample;

    logic [TS_W-1:0]   walk_ts;
    logic [TICK_W-1:0] walk_total;
    logic [TICK_W-1:0] walk_idle;

    int send_idle_pct = 28;
    int recv_stall_pct = 65;
    int samples_in = 0;
    int samples_skipped = 0;
    int records_seen = 0;
    int errors = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    function automatic logic [31:0] at_least_one(input logic [31:0] v);
        return (v == 0) ? 32'd1 : v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic rollup_sample(input sample_t s);
        logic [TICK_W-1:0] now_total;
        logic [TICK_W-1:0] now_idle;
        logic [63:0]       span;
        logic [63:0]       idle_span;
        logic [31:0]       cpu;
        logic [31:0]       mem;
        logic [31:0]       bkt;
        logic [31:0]       cnt;
        now_total = s.cpu_ok ? s.total : '0;
        now_idle = s.cpu_ok ? s.idle : '0;
        if (!old_ok || !s.cpu_ok || now_total <= old_total)
        begin
            old_ok = s.cpu_ok;
            old_total = now_total;
            old_idle = now_idle;
            samples_skipped++;
            return;
        end
        span = 64'(now_total - old_total);
        if (now_idle < old_idle)
            idle_span = span;
        else
        begin
            idle_span = 64'(now_idle - old_idle);
            if (idle_span > span)
                idle_span = span;
        end
        cpu = 32'(((span - idle_span) * 64'd100 + span / 64'd2) / span);
        old_ok = 1'b1;
        old_total = now_total;
        old_idle = now_idle;
        if (!s.mem_ok)
        begin
            samples_skipped++;
            return;
        end
        mem = (s.mem > PCT_MAX) ? 32'(PCT_MAX) : 32'(s.mem);

        bkt = s.ts / at_least_one(32'(raw_interval_cfg));
        record_q.insert(record_q.size(),
                        rec_t'{tier: '0,
                               slot: SLOT_W'(bkt % at_least_one(32'(raw_slots_cfg))),
                               bucket: bkt, cpu_avg: PCT_W'(cpu), cpu_pk: PCT_W'(cpu),
                               mem_avg: PCT_W'(mem), mem_pk: PCT_W'(mem), last: 1'b0});
        for (int i = 0; i < ACTIVE_TIERS; i++)
        begin
            bkt = s.ts / at_least_one(32'(tier_interval_cfg[i]));
            if (agg_bucket[i] != bkt)
            begin
                agg_bucket[i] = bkt;
                agg_cpu_sum[i] = 0;
                agg_mem_sum[i] = 0;
                agg_cpu_max[i] = 0;
                agg_mem_max[i] = 0;
                agg_count[i] = 0;
            end
            if (agg_count[i] < 32'(CNT_MAX))
            begin
                agg_cpu_sum[i] += cpu;
                agg_mem_sum[i] += mem;
                agg_count[i]++;
            end
            if (cpu > agg_cpu_max[i])
                agg_cpu_max[i] = cpu;
            if (mem > agg_mem_max[i])
                agg_mem_max[i] = mem;
            cnt = at_least_one(agg_count[i]);
            record_q.insert(record_q.size(),
                            rec_t'{tier: TIER_OUT_W'(i + 1),
                                   slot: SLOT_W'(bkt % at_least_one(32'(tier_slots_cfg))),
                                   bucket: bkt,
                                   cpu_avg: PCT_W'((agg_cpu_sum[i] + cnt / 2) / cnt),
                                   cpu_pk: PCT_W'(agg_cpu_max[i]),
                                   mem_avg: PCT_W'((agg_mem_sum[i] + cnt / 2) / cnt),
                                   mem_pk: PCT_W'(agg_mem_max[i]),
                                   last: (i == ACTIVE_TIERS - 1)});
        end
    endtask

    task automatic push_sample(input logic [TS_W-1:0] ts, input logic [TICK_W-1:0] total,
                               input logic [TICK_W-1:0] idle, input logic cpu_ok,
                               input logic [PCT_W-1:0] mem, input logic mem_ok);
        sample_q.insert(sample_q.size(),
                        sample_t'{ts: ts, total: total, idle: idle, cpu_ok: cpu_ok,
                                  mem: mem, mem_ok: mem_ok});
    endtask

    // mostly well-formed counter walks, with invalid, stalled and backward readings mixed in
    task automatic queue_walk(input int count);
        sample_t s;
        int      pick;
        int      step;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            step = $urandom_range(4000, 1);
            walk_ts += ($urandom_range(9) == 0) ? $urandom_range(5000) : $urandom_range(25);
            s.cpu_ok = 1'b1;
            s.mem_ok = 1'b1;
            s.mem = PCT_W'($urandom_range(100));
            if (pick < 78)
            begin
                walk_total += TICK_W'(step);
                walk_idle += TICK_W'($urandom_range(step));
            end
            else if (pick < 86)
            begin
                walk_ts = $urandom;
                walk_total = TICK_W'({$urandom, $urandom});
                walk_idle = TICK_W'({$urandom, $urandom});
                s.cpu_ok = 1'b0;
                s.mem_ok = 1'($urandom_range(1));
                s.mem = PCT_W'($urandom_range(127));
            end
            else if (pick < 91)
            begin
                walk_total += TICK_W'(step);
                walk_idle += TICK_W'($urandom_range(step));
                s.mem_ok = 1'b0;
            end
            else if (pick < 95)
            begin
                walk_total += TICK_W'(step);
                walk_idle += TICK_W'($urandom_range(step));
                s.mem = PCT_W'($urandom_range(127, 101));
            end
            else if (pick < 97)
                walk_total -= TICK_W'($urandom_range(3));
            else
            begin
                walk_total += TICK_W'(step);
                if ($urandom_range(1))
                    walk_idle -= TICK_W'($urandom_range(50, 1));
                else
                    walk_idle += TICK_W'(step) + TICK_W'($urandom_range(100, 1));
            end
            s.ts = walk_ts;
            s.total = walk_total;
            s.idle = walk_idle;
            sample_q.insert(sample_q.size(), s);
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RAW_INTERVAL:   raw_interval_cfg = value[INTV_W-1:0];
            REG_RAW_SLOTS:      raw_slots_cfg = value[INTV_W-1:0];
            REG_TIER1_INTERVAL: tier_interval_cfg[0] = value[INTV_W-1:0];
            REG_TIER2_INTERVAL: tier_interval_cfg[1] = value[INTV_W-1:0];
            REG_TIER3_INTERVAL: tier_interval_cfg[2] = value[INTV_W-1:0];
            REG_TIER4_INTERVAL: tier_interval_cfg[3] = value[INTV_W-1:0];
            REG_TIER_SLOTS:     tier_slots_cfg = value[TSLOT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        check_field("prdata", prdata, (idx == REG_TIER_SLOTS) ? 32'(value[TSLOT_W-1:0])
                                                               : 32'(value[INTV_W-1:0]));
    endtask

    task automatic write_all(input logic [DATA_W-1:0] raw_iv, input logic [DATA_W-1:0] raw_sl,
                             input logic [DATA_W-1:0] t1, input logic [DATA_W-1:0] t2,
                             input logic [DATA_W-1:0] t3, input logic [DATA_W-1:0] t4,
                             input logic [DATA_W-1:0] t_sl);
        write_reg(REG_RAW_INTERVAL, raw_iv);
        write_reg(REG_RAW_SLOTS, raw_sl);
        write_reg(REG_TIER1_INTERVAL, t1);
        write_reg(REG_TIER2_INTERVAL, t2);
        write_reg(REG_TIER3_INTERVAL, t3);
        write_reg(REG_TIER4_INTERVAL, t4);
        write_reg(REG_TIER_SLOTS, t_sl);
    endtask

    // wait for the block to drain
    task automatic settle();
        while (sample_q.size() != 0 || in_valid || record_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, record_q.size());
            $display("tiered_usage_rollup_unit_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                rollup_sample(driven_sample);
                samples_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_sample = sample_q.pop_front();
                    in_valid <= 1'b1;
                    timestamp <= driven_sample.ts;
                    cpu_total_ticks <= driven_sample.total;
                    cpu_idle_ticks <= driven_sample.idle;
                    cpu_valid <= driven_sample.cpu_ok;
                    mem_percent <= driven_sample.mem;
                    mem_valid <= driven_sample.mem_ok;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rec_t got;
        rec_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{tier: tier, slot: slot, bucket: bucket, cpu_avg: cpu_average,
                        cpu_pk: cpu_peak, mem_avg: mem_average, mem_pk: mem_peak,
                        last: last};
                records_seen++;
                if (record_q.size() == 0)
                    report_mismatch($sformatf("unexpected record tier %0d bucket %0d",
                                              got.tier, got.bucket));
                else
                begin
                    want = record_q.pop_front();
                    check_field("tier", 32'(got.tier), 32'(want.tier));
                    check_field("slot", 32'(got.slot), 32'(want.slot));
                    check_field("bucket", got.bucket, want.bucket);
                    check_field("cpu_average", 32'(got.cpu_avg), 32'(want.cpu_avg));
                    check_field("cpu_peak", 32'(got.cpu_pk), 32'(want.cpu_pk));
                    check_field("mem_average", 32'(got.mem_avg), 32'(want.mem_avg));
                    check_field("mem_peak", 32'(got.mem_pk), 32'(want.mem_pk));
                    check_field("last", 32'(got.last), 32'(want.last));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        tier_interval_cfg[0] = TIER1_RST;
        tier_interval_cfg[1] = TIER2_RST;
        tier_interval_cfg[2] = TIER3_RST;
        tier_interval_cfg[3] = TIER4_RST;
        for (int i = 0; i < 4; i++)
        begin
            agg_bucket[i] = 0;
            agg_cpu_sum[i] = 0;
            agg_mem_sum[i] = 0;
            agg_cpu_max[i] = 0;
            agg_mem_max[i] = 0;
            agg_count[i] = 0;
        end
        walk_ts = $urandom;
        walk_total = TICK_W'({$urandom_range(255), $urandom});
        walk_idle = walk_total >> 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed samples under reset settings
        push_sample(32'd0, 48'd1000, 48'd500, 1'b1, 7'd0, 1'b1);
        push_sample(32'd5, 48'd1004, 48'd502, 1'b1, 7'd100, 1'b1);
        push_sample(32'd9, 48'd1007, 48'd503, 1'b1, 7'd127, 1'b1);
        push_sample(32'd12, 48'd1010, 48'd505, 1'b1, 7'd1, 1'b1);
        push_sample(32'd14, 48'd1110, 48'd400, 1'b1, 7'd50, 1'b1);
        push_sample(32'd20, 48'd1120, 48'd1000, 1'b1, 7'd64, 1'b1);
        push_sample(32'd22, 48'd1120, 48'd1001, 1'b1, 7'd10, 1'b1);
        push_sample(32'd24, 48'd900, 48'd800, 1'b1, 7'd10, 1'b1);
        push_sample(32'd26, 48'd1000, 48'd950, 1'b1, 7'd20, 1'b0);
        push_sample(32'd27, 48'hA5A5_5A5A_F00F, 48'h0F0F_F0F0_1234, 1'b0, 7'd30, 1'b1);
        push_sample(32'd28, 48'd50, 48'd10, 1'b1, 7'd40, 1'b1);
        push_sample(32'd29, 48'd150, 48'd60, 1'b1, 7'd45, 1'b1);
        push_sample(32'd30, 48'd250, 48'd60, 1'b1, 7'd99, 1'b1);
        push_sample(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE, 1'b1, 7'd127, 1'b1);
        push_sample(32'd0, 48'd0, 48'd0, 1'b1, 7'd0, 1'b1);
        push_sample(32'd0, 48'd100, 48'd0, 1'b1, 7'd0, 1'b1);
        push_sample(32'd7, 48'd300, 48'd100, 1'b1, 7'd100, 1'b1);
        push_sample(32'd7, 48'd301, 48'd100, 1'b1, 7'd3, 1'b1);
        push_sample(32'd8, 48'd302, 48'd101, 1'b1, 7'd77, 1'b1);
        push_sample(32'd9, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 7'd127, 1'b0);
        push_sample(32'd10, 48'd10, 48'd5, 1'b1, 7'd55, 1'b1);
        push_sample(32'd11, 48'd17, 48'd6, 1'b1, 7'd56, 1'b1);
        settle();

        write_all(32'd1, 32'd65535, 32'd3, 32'd7, 32'd20, 32'd65535, 32'd255);
        queue_walk(83);
        settle();

        send_idle_pct = 65;
        recv_stall_pct = 28;
        write_all(32'd65535, 32'd1, 32'd1, 32'd2, 32'd5, 32'd60, 32'd1);
        queue_walk(83);
        settle();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_all(32'd0, 32'd0, 32'd0, $urandom_range(64, 8), $urandom_range(65535, 1),
                  32'd1000, 32'd0);
        queue_walk(83);
        settle();

        $display("%0d samples taken, %0d skipped, %0d records checked over four settings",
                 samples_in, samples_skipped, records_seen);
        $display("register extremes, zero values and all three idle/stall mixes exercised");
        if (errors == 0)
            $display("tiered_usage_rollup_unit_tb passed");
        else
            $display("tiered_usage_rollup_unit_tb failed");
        $finish;
    end

endmodule
